### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication: the consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mr_pkg.sv
// Types and constants shared by the Miller-Rabin round block.
package mr_pkg;

    localparam int unsigned DATA_W = 64;

    localparam logic [1:0] VERDICT_TRIVIAL = 2'd0;
    localparam logic [1:0] VERDICT_WITNESS = 2'd1;
    localparam logic [1:0] VERDICT_PRIME   = 2'd2;

    typedef enum logic {
        MM_OP_MUL,
        MM_OP_RED
    } mm_op_t;

    typedef struct packed {
        logic   start;
        mm_op_t op;
    } mm_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STRIP,
        S_RED_GO,
        S_RED_WAIT,
        S_POW,
        S_ACC_GO,
        S_ACC_WAIT,
        S_BASE_GO,
        S_BASE_WAIT,
        S_SQ_CHECK,
        S_SQ_GO,
        S_SQ_WAIT,
        S_DONE
    } state_t;

endpackage

### rtl/core/mr_modmul.sv
// Shared shift-add modular multiplier and bit-serial modular reducer.
module mr_modmul #(
    parameter int unsigned N = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mr_pkg::mm_req_t    req,
    input  logic [N-1:0]       op_x,
    input  logic [N-1:0]       op_y,
    input  logic [N-1:0]       modulus,
    output mr_pkg::mm_rsp_t    rsp,
    output logic [N-1:0]       result
);

    localparam int unsigned CW = $clog2(N + 1);

    logic           run_reg, run_next;
    logic           done_reg, done_next;
    mr_pkg::mm_op_t op_reg, op_next;
    logic [N-1:0]   acc_reg, acc_next;
    logic [N-1:0]   add_reg, add_next;
    logic [N-1:0]   y_reg, y_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [N-1:0]   room_acc, room_add;
    logic [N:0]     dbl;

    // Modular additions: both operands are below the modulus, so no overflow.
    always_comb
    begin
        room_acc = modulus - add_reg;
        room_add = modulus - add_reg;
        dbl      = {acc_reg, y_reg[N-1]};
    end

    // One step of the selected operation per cycle.
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        acc_next  = acc_reg;
        add_next  = add_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            op_next  = req.op;
            acc_next = '0;
            add_next = op_x;
            y_next   = (req.op == mr_pkg::MM_OP_MUL) ? op_y : op_x;
            cnt_next = CW'(N);
        end
        else if (run_reg)
        begin
            if (op_reg == mr_pkg::MM_OP_MUL)
            begin
                if (y_reg == '0)
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    if (y_reg[0])
                    begin
                        acc_next = (acc_reg >= room_acc) ? (acc_reg - room_acc)
                                                         : (acc_reg + add_reg);
                    end
                    add_next = (add_reg >= room_add) ? (add_reg - room_add)
                                                     : (add_reg + add_reg);
                    y_next   = y_reg >> 1;
                end
            end
            else
            begin
                if (cnt_reg == '0)
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    acc_next = (dbl >= {1'b0, modulus}) ? N'(dbl - {1'b0, modulus})
                                                        : N'(dbl);
                    y_next   = y_reg << 1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
        add_reg <= add_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.busy = run_reg;
    assign rsp.done = done_reg;
    assign result   = acc_reg;

endmodule

### rtl/core/miller_rabin_round.sv
// Top level: one Miller-Rabin round on a candidate and a witness.
//
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   candidate, witness
//  output   out_valid / out_ready tested_value, verdict
//
// One item at a time; in_ready is high only while idle.
// Trivial rejects go from idle straight to the done state. Otherwise the
// shared shift-add multiplier computes each modular product, and the power
// and the squarings together need at most 2N products, since they split the
// N bits of p-1 between them.
// Reset is asynchronous, active low, and returns the sequencer to idle.
// A result holds on the output until out_ready takes it.
`include "assert_macros.svh"

module miller_rabin_round #(
    parameter int unsigned NUMBER_WIDTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [mr_pkg::DATA_W-1:0] candidate,
    input  logic [mr_pkg::DATA_W-1:0] witness,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mr_pkg::DATA_W-1:0] tested_value,
    output logic [1:0]                verdict
);

    localparam int unsigned N  = NUMBER_WIDTH;
    localparam int unsigned CW = $clog2(N + 1);

    mr_pkg::state_t  state_reg, state_next;
    logic [N-1:0]    p_reg, p_next;
    logic [N-1:0]    pm1_reg, pm1_next;
    logic [N-1:0]    e_reg, e_next;
    logic [N-1:0]    base_reg, base_next;
    logic [N-1:0]    acc_reg, acc_next;
    logic [CW-1:0]   r_reg, r_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [1:0]      verdict_reg, verdict_next;

    logic [N-1:0]    in_p;
    logic            trivial;
    logic            sq_stop;
    mr_pkg::mm_req_t mm_req;
    mr_pkg::mm_rsp_t mm_rsp;
    logic [N-1:0]    mm_x, mm_y, mm_res;

    // Input decode and the stop test of the squaring phase.
    always_comb
    begin
        in_p    = candidate[N-1:0];
        trivial = (in_p[N-1:1] == '0) || (!in_p[0] && (in_p != N'(2)));
        sq_stop = (k_reg == r_reg) || (acc_reg == N'(1)) || (acc_reg == pm1_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (trivial || in_p == N'(2)) ? mr_pkg::S_DONE
                                                            : mr_pkg::S_STRIP;
                end
            end
            mr_pkg::S_STRIP:     if (e_reg[0]) state_next = mr_pkg::S_RED_GO;
            mr_pkg::S_RED_GO:    state_next = mr_pkg::S_RED_WAIT;
            mr_pkg::S_RED_WAIT:  if (mm_rsp.done) state_next = mr_pkg::S_POW;
            mr_pkg::S_POW:
            begin
                if (e_reg == '0)
                    state_next = mr_pkg::S_SQ_CHECK;
                else if (e_reg[0])
                    state_next = mr_pkg::S_ACC_GO;
                else
                    state_next = mr_pkg::S_BASE_GO;
            end
            mr_pkg::S_ACC_GO:    state_next = mr_pkg::S_ACC_WAIT;
            mr_pkg::S_ACC_WAIT:  if (mm_rsp.done) state_next = mr_pkg::S_BASE_GO;
            mr_pkg::S_BASE_GO:   state_next = mr_pkg::S_BASE_WAIT;
            mr_pkg::S_BASE_WAIT: if (mm_rsp.done) state_next = mr_pkg::S_POW;
            mr_pkg::S_SQ_CHECK:
                state_next = sq_stop ? mr_pkg::S_DONE : mr_pkg::S_SQ_GO;
            mr_pkg::S_SQ_GO:     state_next = mr_pkg::S_SQ_WAIT;
            mr_pkg::S_SQ_WAIT:   if (mm_rsp.done) state_next = mr_pkg::S_SQ_CHECK;
            mr_pkg::S_DONE:      if (out_ready) state_next = mr_pkg::S_IDLE;
            default:             state_next = mr_pkg::S_IDLE;
        endcase
    end

    // Handshake and multiplier requests.
    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        mm_req.start = 1'b0;
        mm_req.op    = mr_pkg::MM_OP_MUL;
        mm_x         = acc_reg;
        mm_y         = base_reg;
        case (state_reg)
            mr_pkg::S_IDLE:   in_ready = 1'b1;
            mr_pkg::S_DONE:   out_valid = 1'b1;
            mr_pkg::S_RED_GO:
            begin
                mm_req.start = 1'b1;
                mm_req.op    = mr_pkg::MM_OP_RED;
                mm_x         = base_reg;
            end
            mr_pkg::S_ACC_GO: mm_req.start = 1'b1;
            mr_pkg::S_BASE_GO:
            begin
                mm_req.start = 1'b1;
                mm_x         = base_reg;
            end
            mr_pkg::S_SQ_GO:
            begin
                mm_req.start = 1'b1;
                mm_y         = acc_reg;
            end
            default:          in_ready = 1'b0;
        endcase
    end

    // Datapath updates.
    always_comb
    begin
        p_next       = p_reg;
        pm1_next     = pm1_reg;
        e_next       = e_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        r_next       = r_reg;
        k_next       = k_reg;
        verdict_next = verdict_reg;
        case (state_reg)
            mr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    p_next       = in_p;
                    pm1_next     = in_p - N'(1);
                    e_next       = in_p - N'(1);
                    base_next    = witness[N-1:0];
                    r_next       = '0;
                    verdict_next = trivial ? mr_pkg::VERDICT_TRIVIAL
                                           : mr_pkg::VERDICT_PRIME;
                end
            end
            mr_pkg::S_STRIP:
            begin
                if (!e_reg[0])
                begin
                    e_next = e_reg >> 1;
                    r_next = r_reg + 1'b1;
                end
            end
            mr_pkg::S_RED_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    base_next = mm_res;
                    acc_next  = N'(1);
                    k_next    = '0;
                end
            end
            mr_pkg::S_ACC_WAIT:  if (mm_rsp.done) acc_next = mm_res;
            mr_pkg::S_BASE_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    base_next = mm_res;
                    e_next    = e_reg >> 1;
                end
            end
            mr_pkg::S_SQ_CHECK:
            begin
                verdict_next = ((acc_reg == pm1_reg) || (k_reg == '0))
                             ? mr_pkg::VERDICT_PRIME : mr_pkg::VERDICT_WITNESS;
            end
            mr_pkg::S_SQ_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    acc_next = mm_res;
                    k_next   = k_reg + 1'b1;
                end
            end
            default:             acc_next = acc_reg;
        endcase
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mr_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        p_reg       <= p_next;
        pm1_reg     <= pm1_next;
        e_reg       <= e_next;
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        r_reg       <= r_next;
        k_reg       <= k_next;
        verdict_reg <= verdict_next;
    end

    // Shared modular arithmetic unit.
    mr_modmul #(
        .N (N)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mm_req),
        .op_x    (mm_x),
        .op_y    (mm_y),
        .modulus (p_reg),
        .rsp     (mm_rsp),
        .result  (mm_res)
    );

    assign tested_value = mr_pkg::DATA_W'(p_reg);
    assign verdict      = verdict_reg;

    // The unit is only started when it is free.
    `ASSERT_CLK(a_start_idle, mm_req.start |-> !mm_rsp.busy, "multiplier started while busy")
    // Once an item is taken, no other item is taken in the next cycle.
    `ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken too early")
    // A delivered verdict is always a defined code.
    `ASSERT_CLK(a_verdict_code, out_valid |-> (verdict != 2'd3), "undefined verdict code")
    // A finished product never arrives while idle or while a result is offered.
    `ASSERT_CLK(a_done_wait, mm_rsp.done |-> !in_ready && !out_valid, "stray multiplier result")

endmodule
